### rtl/jsu_pkg.sv
// Shared types, codes and UTF-8 helpers for the JSON string unescaper.
// Used by jsu_front, jsu_queue, jsu_back and json_string_unescape_to_utf8_core.
package jsu_pkg;

   typedef enum logic [2:0] {
      MODE_BODY          = 3'd0,
      MODE_ESC           = 3'd1,
      MODE_HEX1          = 3'd2,
      MODE_AFTER_HIGH    = 3'd3,
      MODE_AFTER_HIGH_BS = 3'd4,
      MODE_HEX2          = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      PH_A  = 2'd0,
      PH_B  = 2'd1,
      PH_ST = 2'd2
   } phase_type;

   localparam logic [2:0] ERR_NONE          = 3'd0;
   localparam logic [2:0] ERR_UNTERM_STRING = 3'd1;
   localparam logic [2:0] ERR_CONTROL       = 3'd2;
   localparam logic [2:0] ERR_UNTERM_ESCAPE = 3'd3;
   localparam logic [2:0] ERR_BAD_ESCAPE    = 3'd4;
   localparam logic [2:0] ERR_SHORT_HEX     = 3'd5;
   localparam logic [2:0] ERR_BAD_HEX       = 3'd6;

   localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;

   // One output element: a raw body byte or a code point to be UTF-8 encoded.
   typedef struct packed {
      logic        vld;
      logic        raw;
      logic [20:0] cp;
   } slot_type;

   // Everything one request produces: up to two elements, then an optional status.
   typedef struct packed {
      slot_type   a;
      slot_type   b;
      logic       st_vld;
      logic       st_done;
      logic [2:0] st_err;
   } job_type;

   function automatic logic [2:0] utf8_len(input logic [20:0] cp);
      logic [2:0] len;
      if (cp[20:7] == 14'd0) begin
         len = 3'd1;
      end else if (cp[20:11] == 10'd0) begin
         len = 3'd2;
      end else if (cp[20:16] == 5'd0) begin
         len = 3'd3;
      end else begin
         len = 3'd4;
      end
      return len;
   endfunction

   function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
                                            input logic [1:0] idx);
      logic [7:0] res;
      res = {2'b10, cp[5:0]};
      case (len)
         3'd1: res = {1'b0, cp[6:0]};
         3'd2: begin
            if (idx == 2'd0) res = {3'b110, cp[10:6]};
         end
         3'd3: begin
            if (idx == 2'd0) res = {4'b1110, cp[15:12]};
            else if (idx == 2'd1) res = {2'b10, cp[11:6]};
         end
         default: begin
            if (idx == 2'd0) res = {5'b11110, cp[20:18]};
            else if (idx == 2'd1) res = {2'b10, cp[17:12]};
            else if (idx == 2'd2) res = {2'b10, cp[11:6]};
         end
      endcase
      return res;
   endfunction

endpackage

### rtl/jsu_front.sv
// Front end: takes body bytes, tracks escape / hex / surrogate state and
// emits one job per request that has results. Depends on jsu_pkg.
module jsu_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  logic [7:0]       text_byte,
   input  logic             input_ended,
   output logic             push,
   output jsu_pkg::job_type job
);

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_U      = 8'h75;

   jsu_pkg::mode_type mode_ff, mode_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [11:0] acc_ff, acc_in;
   logic [9:0]  saved_ff, saved_in;
   logic        bad_ff, bad_in;

   logic [4:0]  hv;
   logic [15:0] hex_cp;
   logic        fin, bad_all, is_low, is_high, is_sur;
   logic        b_quote, b_ctrl, b_bs, b_u;
   logic [8:0]  esc;
   logic [20:0] pair_cp;

   // bit 4 flags a non-hex byte
   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [4:0] v;
      if (c >= 8'h30 && c <= 8'h39) v = {1'b0, c[3:0]};
      else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
         v = {1'b0, c[3:0] + 4'd9};
      else v = 5'h10;
      return v;
   endfunction

   // bit 8 set when the byte is a simple escape character
   function automatic logic [8:0] esc_lookup(input logic [7:0] e);
      logic [8:0] r;
      case (e)
         8'h22, 8'h5C, 8'h2F: r = {1'b1, e};
         8'h62:   r = {1'b1, 8'h08};
         8'h66:   r = {1'b1, 8'h0C};
         8'h6E:   r = {1'b1, 8'h0A};
         8'h72:   r = {1'b1, 8'h0D};
         8'h74:   r = {1'b1, 8'h09};
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   function automatic jsu_pkg::slot_type mk_cp(input logic [20:0] cp);
      jsu_pkg::slot_type s;
      s.vld = 1'b1;
      s.raw = 1'b0;
      s.cp  = cp;
      return s;
   endfunction

   function automatic jsu_pkg::slot_type mk_raw(input logic [7:0] b);
      jsu_pkg::slot_type s;
      s.vld = 1'b1;
      s.raw = 1'b1;
      s.cp  = {13'd0, b};
      return s;
   endfunction

   assign hv      = hex_val(text_byte);
   assign hex_cp  = {acc_ff, hv[4] ? 4'd0 : hv[3:0]};
   assign fin     = (cnt_ff == 2'd3);
   assign bad_all = bad_ff | hv[4];
   assign is_high = (hex_cp[15:10] == 6'b110110);
   assign is_low  = (hex_cp[15:10] == 6'b110111);
   assign is_sur  = (hex_cp[15:11] == 5'b11011);
   assign pair_cp = 21'h010000 + {1'b0, saved_ff, hex_cp[9:0]};
   assign b_quote = (text_byte == CH_QUOTE);
   assign b_ctrl  = (text_byte[7:5] == 3'd0);
   assign b_bs    = (text_byte == CH_BSLASH);
   assign b_u     = (text_byte == CH_U);
   assign esc     = esc_lookup(text_byte);

   // next state
   always_comb begin
      logic clr;
      clr      = 1'b0;
      mode_in  = mode_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      saved_in = saved_ff;
      bad_in   = bad_ff;
      if (fire) begin
         case (mode_ff)
            jsu_pkg::MODE_ESC: begin
               if (input_ended) begin
                  clr = 1'b1;
               end else if (b_u) begin
                  mode_in = jsu_pkg::MODE_HEX1;
                  cnt_in  = 2'd0;
                  acc_in  = 12'd0;
                  bad_in  = 1'b0;
               end else if (esc[8]) begin
                  mode_in = jsu_pkg::MODE_BODY;
               end else begin
                  clr = 1'b1;
               end
            end
            jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
               if (input_ended) begin
                  clr = 1'b1;
               end else if (fin) begin
                  if (bad_all) begin
                     clr = 1'b1;
                  end else begin
                     cnt_in  = 2'd0;
                     acc_in  = 12'd0;
                     mode_in = jsu_pkg::MODE_BODY;
                     if (mode_ff == jsu_pkg::MODE_HEX2) begin
                        saved_in = 10'd0;
                     end else if (is_high) begin
                        saved_in = hex_cp[9:0];
                        mode_in  = jsu_pkg::MODE_AFTER_HIGH;
                     end
                  end
               end else begin
                  cnt_in = cnt_ff + 2'd1;
                  acc_in = hex_cp[11:0];
                  bad_in = bad_all;
               end
            end
            jsu_pkg::MODE_AFTER_HIGH: begin
               if (!input_ended && b_bs) begin
                  mode_in = jsu_pkg::MODE_AFTER_HIGH_BS;
               end else begin
                  saved_in = 10'd0;
                  if (input_ended || b_quote || b_ctrl) clr = 1'b1;
                  else mode_in = b_bs ? jsu_pkg::MODE_ESC : jsu_pkg::MODE_BODY;
               end
            end
            jsu_pkg::MODE_AFTER_HIGH_BS: begin
               if (!input_ended && b_u) begin
                  mode_in = jsu_pkg::MODE_HEX2;
                  cnt_in  = 2'd0;
                  acc_in  = 12'd0;
                  bad_in  = 1'b0;
               end else begin
                  saved_in = 10'd0;
                  if (input_ended || !esc[8]) clr = 1'b1;
                  else mode_in = jsu_pkg::MODE_BODY;
               end
            end
            default: begin
               if (input_ended || b_quote || b_ctrl) clr = 1'b1;
               else mode_in = b_bs ? jsu_pkg::MODE_ESC : jsu_pkg::MODE_BODY;
            end
         endcase
      end
      if (clr) begin
         mode_in  = jsu_pkg::MODE_BODY;
         cnt_in   = 2'd0;
         acc_in   = 12'd0;
         saved_in = 10'd0;
         bad_in   = 1'b0;
      end
   end

   // job built from the current request
   always_comb begin
      job = '0;
      case (mode_ff)
         jsu_pkg::MODE_ESC: begin
            if (input_ended) begin
               job.st_vld = 1'b1;
               job.st_err = jsu_pkg::ERR_UNTERM_ESCAPE;
            end else if (esc[8]) begin
               job.a = mk_cp({13'd0, esc[7:0]});
            end else if (!b_u) begin
               job.st_vld = 1'b1;
               job.st_err = jsu_pkg::ERR_BAD_ESCAPE;
            end
         end
         jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
            if (input_ended) begin
               job.st_vld = 1'b1;
               job.st_err = jsu_pkg::ERR_SHORT_HEX;
            end else if (fin) begin
               if (bad_all) begin
                  job.st_vld = 1'b1;
                  job.st_err = jsu_pkg::ERR_BAD_HEX;
               end else if (mode_ff == jsu_pkg::MODE_HEX2) begin
                  if (is_low) begin
                     job.a = mk_cp(pair_cp);
                  end else begin
                     job.a = mk_cp(jsu_pkg::CP_REPLACEMENT);
                     job.b = mk_cp(is_sur ? jsu_pkg::CP_REPLACEMENT : {5'd0, hex_cp});
                  end
               end else if (is_low) begin
                  job.a = mk_cp(jsu_pkg::CP_REPLACEMENT);
               end else if (!is_high) begin
                  job.a = mk_cp({5'd0, hex_cp});
               end
            end
         end
         jsu_pkg::MODE_AFTER_HIGH: begin
            if (input_ended || !b_bs) begin
               job.a = mk_cp(jsu_pkg::CP_REPLACEMENT);
               if (input_ended) begin
                  job.st_vld = 1'b1;
                  job.st_err = jsu_pkg::ERR_UNTERM_STRING;
               end else if (b_quote) begin
                  job.st_vld  = 1'b1;
                  job.st_done = 1'b1;
               end else if (b_ctrl) begin
                  job.st_vld = 1'b1;
                  job.st_err = jsu_pkg::ERR_CONTROL;
               end else begin
                  job.b = mk_raw(text_byte);
               end
            end
         end
         jsu_pkg::MODE_AFTER_HIGH_BS: begin
            if (input_ended || !b_u) begin
               job.a = mk_cp(jsu_pkg::CP_REPLACEMENT);
               if (input_ended) begin
                  job.st_vld = 1'b1;
                  job.st_err = jsu_pkg::ERR_UNTERM_ESCAPE;
               end else if (esc[8]) begin
                  job.b = mk_cp({13'd0, esc[7:0]});
               end else begin
                  job.st_vld = 1'b1;
                  job.st_err = jsu_pkg::ERR_BAD_ESCAPE;
               end
            end
         end
         default: begin
            if (input_ended) begin
               job.st_vld = 1'b1;
               job.st_err = jsu_pkg::ERR_UNTERM_STRING;
            end else if (b_quote) begin
               job.st_vld  = 1'b1;
               job.st_done = 1'b1;
            end else if (b_ctrl) begin
               job.st_vld = 1'b1;
               job.st_err = jsu_pkg::ERR_CONTROL;
            end else if (!b_bs) begin
               job.a = mk_raw(text_byte);
            end
         end
      endcase
   end

   assign push = fire && (job.a.vld || job.b.vld || job.st_vld);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= jsu_pkg::MODE_BODY;
         cnt_ff   <= 2'd0;
         acc_ff   <= 12'd0;
         saved_ff <= 10'd0;
         bad_ff   <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         cnt_ff   <= cnt_in;
         acc_ff   <= acc_in;
         saved_ff <= saved_in;
         bad_ff   <= bad_in;
      end
   end

endmodule

### rtl/jsu_queue.sv
// Small job queue between the decoder front end and the byte serializer.
// Depends on jsu_pkg for the job type.
module jsu_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jsu_pkg::job_type push_job,
   input  logic             pop,
   output jsu_pkg::job_type head,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   jsu_pkg::job_type store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/jsu_back.sv
// Back end: walks the job at the queue head and sends one result per cycle while
// rsp_tready is high, UTF-8 encoding code points byte by byte. Depends on jsu_pkg.
module jsu_back (
   input  logic             clock,
   input  logic             reset,
   input  jsu_pkg::job_type head,
   input  logic             empty,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,
   output logic [4:0]       rsp_tuser,
   output logic             rsp_tlast
);

   jsu_pkg::phase_type phase_ff, phase_in, cur;
   logic [1:0]        idx_ff, idx_in;
   jsu_pkg::slot_type sel;
   logic [2:0]        len;
   logic              elem_last, more, fire;

   // first element still to send, at or after the stored phase
   always_comb begin
      if (phase_ff == jsu_pkg::PH_A && head.a.vld) begin
         cur = jsu_pkg::PH_A;
      end else if (phase_ff != jsu_pkg::PH_ST && head.b.vld) begin
         cur = jsu_pkg::PH_B;
      end else begin
         cur = jsu_pkg::PH_ST;
      end
      sel       = (cur == jsu_pkg::PH_A) ? head.a : head.b;
      len       = sel.raw ? 3'd1 : jsu_pkg::utf8_len(sel.cp);
      elem_last = (cur == jsu_pkg::PH_ST) || ({1'b0, idx_ff} == len - 3'd1);
      case (cur)
         jsu_pkg::PH_A: more = head.b.vld || head.st_vld;
         jsu_pkg::PH_B: more = head.st_vld;
         default:       more = 1'b0;
      endcase
   end

   assign fire = rsp_tvalid && rsp_tready;
   assign pop  = fire && rsp_tlast;

   // next state
   always_comb begin
      phase_in = phase_ff;
      idx_in   = idx_ff;
      if (fire) begin
         if (!more && elem_last) begin
            phase_in = jsu_pkg::PH_A;
            idx_in   = 2'd0;
         end else if (elem_last) begin
            phase_in = (cur == jsu_pkg::PH_A) ? jsu_pkg::PH_B : jsu_pkg::PH_ST;
            idx_in   = 2'd0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   // outputs; tuser = {error_code, string_done, byte_valid}
   always_comb begin
      rsp_tvalid = !empty;
      rsp_tlast  = elem_last && !more;
      if (cur == jsu_pkg::PH_ST) begin
         rsp_tdata = 8'd0;
         rsp_tuser = {head.st_err, head.st_done, 1'b0};
      end else begin
         rsp_tdata = sel.raw ? sel.cp[7:0] : jsu_pkg::utf8_byte(sel.cp, len, idx_ff);
         rsp_tuser = {jsu_pkg::ERR_NONE, 1'b0, 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= jsu_pkg::PH_A;
         idx_ff   <= 2'd0;
      end else begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

### rtl/json_string_unescape_to_utf8_core.sv
// Top level of the JSON string unescaper: front decoder, job queue, serializer.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.

// Feed the bytes of a JSON string body, starting after the opening quote, one
// request per cycle; req_tuser high marks end of text with no byte. The front
// decoder takes a request every cycle while the job queue (QUEUE_DEPTH jobs)
// has room and turns it into zero to six results; the serializer sends one
// result per cycle while rsp_tready is high, and multi-byte UTF-8 output is
// absorbed by the queue. Each run of results ends with tlast. A closing quote
// yields a status result with string_done; errors yield a status result with
// an error code, after which the next request starts a new string body. Bytes
// already sent for a failed string should be dropped by the consumer.
module json_string_unescape_to_utf8_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] text_byte
   input  logic       req_tuser,   // [0] input_ended
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] utf8_byte
   output logic [4:0] rsp_tuser,   // [0] byte_valid, [1] string_done, [4:2] error_code
   output logic       rsp_tlast    // last_of_run
);

   jsu_pkg::job_type job, head;
   logic push, pop, full, empty, req_fire;

   assign req_tready = !full;
   assign req_fire   = req_tvalid && req_tready;

   jsu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .fire        (req_fire),
      .text_byte   (req_tdata),
      .input_ended (req_tuser),
      .push        (push),
      .job         (job)
   );

   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (job),
      .pop      (pop),
      .head     (head),
      .full     (full),
      .empty    (empty)
   );

   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTH
   // status results always close the run of a request
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast)
      else $error("status result not last of run");

   // byte results carry no status
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tuser[4:1] == 4'd0)
      else $error("byte result carries status");

   // done and error never together
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[4:2] == jsu_pkg::ERR_NONE)
      else $error("done with error code");

   // a full queue never takes a job
   assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("job pushed into full queue");
`endif

endmodule

### dv/json_string_unescape_checker.sv
// Watches both streams of the JSON string unescaper, predicts the UTF-8 output of every
// accepted request and compares it with what the block sends. Depends on jsu_pkg.
`timescale 1ns / 1ps

module json_string_unescape_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] text_byte
   input  logic       req_tuser,   // [0] input_ended
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,   // [7:0] utf8_byte
   input  logic [4:0] rsp_tuser,   // [0] byte_valid, [1] string_done, [4:2] error_code
   input  logic       rsp_tlast,   // last_of_run
   output int         fail_count,
   output int         awaited_count,
   output int         requests_seen,
   output int         bytes_seen,
   output int         strings_closed,
   output int         errors_reported
);

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_UA     = 8'h41;
   localparam logic [7:0] CH_UF     = 8'h46;
   localparam logic [7:0] CH_LA     = 8'h61;
   localparam logic [7:0] CH_LF     = 8'h66;
   localparam logic [7:0] CTRL_BS   = 8'h08;
   localparam logic [7:0] CTRL_FF   = 8'h0C;
   localparam logic [7:0] CTRL_LF   = 8'h0A;
   localparam logic [7:0] CTRL_CR   = 8'h0D;
   localparam logic [7:0] CTRL_TAB  = 8'h09;

   localparam logic [15:0] HIGH_FIRST = 16'hD800;
   localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
   localparam logic [15:0] LOW_FIRST  = 16'hDC00;
   localparam logic [15:0] LOW_LAST   = 16'hDFFF;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       done;
      logic [2:0] err;
      logic       last;
   } utf8_out_type;

   utf8_out_type      utf8_expected[$];
   jsu_pkg::mode_type dec_mode;
   logic [2:0]        hex_cnt;
   logic [15:0]       hex_acc;
   logic [9:0]        high_half;
   logic              hex_bad;
   int                step_results;
   int                mismatches;
   int                responses;

   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      if (c >= CH_0 && c <= CH_9) return {1'b0, c[3:0]};
      if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF)) return 5'(c[3:0] + 4'd9);
      return 5'd16;
   endfunction

   task automatic clear_decoder();
      dec_mode  = jsu_pkg::MODE_BODY;
      hex_cnt   = 3'd0;
      hex_acc   = 16'd0;
      high_half = 10'd0;
      hex_bad   = 1'b0;
   endtask

   task automatic start_hex(input jsu_pkg::mode_type m);
      dec_mode = m;
      hex_cnt  = 3'd0;
      hex_acc  = 16'd0;
      hex_bad  = 1'b0;
   endtask

   task automatic expect_out(input logic [7:0] b, input logic v, input logic d,
                             input logic [2:0] e);
      utf8_out_type item;
      item = '{data: b, valid: v, done: d, err: e, last: 1'b0};
      utf8_expected.insert(utf8_expected.size(), item);
      step_results++;
   endtask

   task automatic expect_byte(input logic [7:0] b);
      expect_out(b, 1'b1, 1'b0, jsu_pkg::ERR_NONE);
   endtask

   // status ends the string and returns the decoder to its idle state
   task automatic expect_status(input logic d, input logic [2:0] e);
      clear_decoder();
      expect_out(8'h00, 1'b0, d, e);
   endtask

   task automatic expect_code_point(input logic [20:0] cp);
      if (cp < 21'h80) begin
         expect_byte(cp[7:0]);
      end else if (cp < 21'h800) begin
         expect_byte({3'b110, cp[10:6]});
         expect_byte({2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
         expect_byte({4'b1110, cp[15:12]});
         expect_byte({2'b10, cp[11:6]});
         expect_byte({2'b10, cp[5:0]});
      end else begin
         expect_byte({5'b11110, cp[20:18]});
         expect_byte({2'b10, cp[17:12]});
         expect_byte({2'b10, cp[11:6]});
         expect_byte({2'b10, cp[5:0]});
      end
   endtask

   task automatic body_char(input logic [7:0] b);
      dec_mode = jsu_pkg::MODE_BODY;
      if (b == CH_QUOTE) expect_status(1'b1, jsu_pkg::ERR_NONE);
      else if (b < CH_SPACE) expect_status(1'b0, jsu_pkg::ERR_CONTROL);
      else if (b == CH_BSLASH) dec_mode = jsu_pkg::MODE_ESC;
      else expect_byte(b);
   endtask

   task automatic escape_char(input logic [7:0] e);
      dec_mode = jsu_pkg::MODE_BODY;
      case (e)
         CH_QUOTE, CH_BSLASH, CH_SLASH: expect_byte(e);
         CH_B:    expect_byte(CTRL_BS);
         CH_F:    expect_byte(CTRL_FF);
         CH_N:    expect_byte(CTRL_LF);
         CH_R:    expect_byte(CTRL_CR);
         CH_T:    expect_byte(CTRL_TAB);
         CH_U:    start_hex(jsu_pkg::MODE_HEX1);
         default: expect_status(1'b0, jsu_pkg::ERR_BAD_ESCAPE);
      endcase
   endtask

   task automatic close_hex();
      logic [15:0] unit;
      logic        second;
      unit   = hex_acc;
      second = (dec_mode == jsu_pkg::MODE_HEX2);
      if (hex_bad) begin
         expect_status(1'b0, jsu_pkg::ERR_BAD_HEX);
      end else begin
         hex_cnt  = 3'd0;
         hex_acc  = 16'd0;
         dec_mode = jsu_pkg::MODE_BODY;
         if (second) begin
            if (unit >= LOW_FIRST && unit <= LOW_LAST) begin
               expect_code_point(21'h10000 + 21'({high_half, unit[9:0]}));
            end else begin
               // broken pair: replacement for the high half, then the second unit, itself replaced if it is a high half
               expect_code_point(jsu_pkg::CP_REPLACEMENT);
               if (unit >= HIGH_FIRST && unit <= LOW_LAST)
                  expect_code_point(jsu_pkg::CP_REPLACEMENT);
               else
                  expect_code_point(21'(unit));
            end
            high_half = 10'd0;
         end else if (unit >= HIGH_FIRST && unit <= HIGH_LAST) begin
            high_half = unit[9:0];
            dec_mode  = jsu_pkg::MODE_AFTER_HIGH;
         end else if (unit >= LOW_FIRST && unit <= LOW_LAST) begin
            expect_code_point(jsu_pkg::CP_REPLACEMENT);
         end else begin
            expect_code_point(21'(unit));
         end
      end
   endtask

   task automatic predict_request(input logic [7:0] b, input logic ended);
      logic [4:0]   nib;
      utf8_out_type tail;
      step_results = 0;
      case (dec_mode)
         jsu_pkg::MODE_ESC: begin
            if (ended) expect_status(1'b0, jsu_pkg::ERR_UNTERM_ESCAPE);
            else escape_char(b);
         end
         jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
            if (ended) begin
               expect_status(1'b0, jsu_pkg::ERR_SHORT_HEX);
            end else begin
               nib = hex_nibble(b);
               if (nib[4]) begin
                  hex_bad = 1'b1;
                  nib = 5'd0;
               end
               hex_acc = {hex_acc[11:0], nib[3:0]};
               hex_cnt = hex_cnt + 3'd1;
               if (hex_cnt >= 3'd4) close_hex();
            end
         end
         jsu_pkg::MODE_AFTER_HIGH: begin
            if (!ended && b == CH_BSLASH) begin
               dec_mode = jsu_pkg::MODE_AFTER_HIGH_BS;
            end else begin
               high_half = 10'd0;
               expect_code_point(jsu_pkg::CP_REPLACEMENT);
               if (ended) expect_status(1'b0, jsu_pkg::ERR_UNTERM_STRING);
               else body_char(b);
            end
         end
         jsu_pkg::MODE_AFTER_HIGH_BS: begin
            if (!ended && b == CH_U) begin
               start_hex(jsu_pkg::MODE_HEX2);
            end else begin
               high_half = 10'd0;
               expect_code_point(jsu_pkg::CP_REPLACEMENT);
               if (ended) expect_status(1'b0, jsu_pkg::ERR_UNTERM_ESCAPE);
               else escape_char(b);
            end
         end
         default: begin
            if (ended) expect_status(1'b0, jsu_pkg::ERR_UNTERM_STRING);
            else body_char(b);
         end
      endcase
      if (step_results > 0) begin
         tail = utf8_expected[utf8_expected.size() - 1];
         tail.last = 1'b1;
         utf8_expected[utf8_expected.size() - 1] = tail;
      end
   endtask

   always @(posedge clock) begin : watch_ports
      utf8_out_type want;
      utf8_out_type got;
      if (reset) begin
         clear_decoder();
         utf8_expected.delete();
         mismatches = 0;
         responses  = 0;
      end else begin
         // requests first: a response in the same cycle belongs to an older request
         if (req_tvalid && req_tready) begin
            requests_seen++;
            predict_request(req_tdata, req_tuser);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '{data: rsp_tdata, valid: rsp_tuser[0], done: rsp_tuser[1],
                    err: rsp_tuser[4:2], last: rsp_tlast};
            responses++;
            if (got.valid) bytes_seen++;
            if (got.done) strings_closed++;
            if (got.err != jsu_pkg::ERR_NONE) errors_reported++;
            if (utf8_expected.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("response %0d not expected: %s", responses,
                           $sformatf("data %02h valid %0b done %0b err %0d last %0b",
                                     got.data, got.valid, got.done, got.err, got.last));
            end else begin
               want = utf8_expected.pop_front();
               if (got.data != want.data || got.valid != want.valid || got.done != want.done ||
                   got.err != want.err || got.last != want.last) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("response %0d: expected %s, %s", responses,
                              $sformatf("data %02h valid %0b done %0b err %0d last %0b",
                                        want.data, want.valid, want.done, want.err,
                                        want.last),
                              $sformatf("got data %02h valid %0b done %0b err %0d last %0b",
                                        got.data, got.valid, got.done, got.err, got.last));
               end
            end
         end
      end
      fail_count    <= mismatches;
      awaited_count <= utf8_expected.size();
   end

endmodule

### dv/json_string_unescape_to_utf8_core_tb.sv
// Top of the unescaper testbench: clock, reset, request and response drivers, verdict.
// Depends on json_string_unescape_to_utf8_core and json_string_unescape_checker.
`timescale 1ns / 1ps

module json_string_unescape_to_utf8_core_tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 270;
   localparam int HOLD_CYCLES  = 150;
   localparam int DRAIN_CYCLES = 20;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CH_X      = 8'h78;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_UA     = 8'h41;
   localparam logic [7:0] CH_LA     = 8'h61;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       req_tuser = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [4:0] rsp_tuser;
   logic       rsp_tlast;

   int   tx_idle_pct = 30;
   int   rx_idle_pct = 55;
   logic hold_wanted = 1'b0;
   logic hold_served = 1'b0;
   int   req_count = 0;
   int   directed_count = 0;
   int   cycle_count = 0;

   int fail_count;
   int awaited_count;
   int requests_seen;
   int bytes_seen;
   int strings_closed;
   int errors_reported;

   json_string_unescape_to_utf8_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   json_string_unescape_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .fail_count      (fail_count),
      .awaited_count   (awaited_count),
      .requests_seen   (requests_seen),
      .bytes_seen      (bytes_seen),
      .strings_closed  (strings_closed),
      .errors_reported (errors_reported)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("json_string_unescape_to_utf8_core verification failed");
         $finish;
      end
   end

   // receiver: random back-pressure, plus one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_wanted && !hold_served) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_served = 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
         end
      end
   end

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return CH_0 + 8'(n);
      if ($urandom_range(0, 1) == 0) return CH_UA + 8'(n) - 8'd10;
      return CH_LA + 8'(n) - 8'd10;
   endfunction

   function automatic logic [7:0] simple_escape(input int i);
      case (i)
         0:       return CH_QUOTE;
         1:       return CH_BSLASH;
         2:       return CH_SLASH;
         3:       return CH_B;
         4:       return CH_F;
         5:       return CH_N;
         6:       return CH_R;
         default: return CH_T;
      endcase
   endfunction

   function automatic logic [15:0] high_unit();
      return 16'hD800 | 16'($urandom_range(0, 1023));
   endfunction

   function automatic logic [15:0] low_unit();
      return 16'hDC00 | 16'($urandom_range(0, 1023));
   endfunction

   // offer one request at the falling edge and hold it until accepted
   task automatic send_req(input logic [7:0] b, input logic ended);
      logic took;
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= ended;
      if (ended) req_tdata <= 8'($urandom_range(0, 255));
      else req_tdata <= b;
      took = 1'b0;
      while (!took) begin
         @(posedge clock);
         took = req_tready;
      end
      @(negedge clock);
      req_count++;
   endtask

   task automatic send_u_escape(input logic [15:0] v);
      send_req(CH_BSLASH, 1'b0);
      send_req(CH_U, 1'b0);
      for (int i = 3; i >= 0; i--) send_req(hex_char(v[i*4 +: 4]), 1'b0);
   endtask

   task automatic send_fragment();
      int          kind;
      int          pos;
      logic [7:0]  c;
      logic [15:0] unit;
      kind = $urandom_range(0, 10);
      case (kind)
         0, 1: begin
            do begin
               if ($urandom_range(0, 3) == 0) c = 8'($urandom_range(128, 255));
               else c = 8'($urandom_range(32, 126));
            end while (c == CH_QUOTE || c == CH_BSLASH);
            send_req(c, 1'b0);
         end
         2: begin
            send_req(CH_BSLASH, 1'b0);
            send_req(simple_escape($urandom_range(0, 7)), 1'b0);
         end
         3: begin
            case ($urandom_range(0, 4))
               0:       unit = 16'($urandom_range(0, 16'h7F));
               1:       unit = 16'($urandom_range(16'h80, 16'h7FF));
               2:       unit = 16'($urandom_range(16'h800, 16'hFFFF));
               3:       unit = low_unit();
               default: unit = 16'($urandom_range(0, 16'hFFFF));
            endcase
            send_u_escape(unit);
         end
         4: begin
            send_u_escape(high_unit());
            send_u_escape(low_unit());
         end
         5: begin
            // high half followed by anything at all
            send_u_escape(high_unit());
            send_req(8'($urandom_range(0, 255)), 1'b0);
         end
         6: begin
            send_u_escape(high_unit());
            send_req(CH_BSLASH, 1'b0);
            if ($urandom_range(0, 1) == 0) send_req(simple_escape($urandom_range(0, 7)), 1'b0);
            else send_req(8'($urandom_range(0, 255)), 1'b0);
         end
         7: begin
            unit = 16'($urandom_range(0, 16'hFFFF));
            if (unit >= 16'hDC00 && unit <= 16'hDFFF) unit = unit ^ 16'h0400;
            send_u_escape(high_unit());
            send_u_escape(unit);
         end
         8: begin
            // four digit slots, one of them not hex
            if ($urandom_range(0, 1) == 0) send_u_escape(high_unit());
            send_req(CH_BSLASH, 1'b0);
            send_req(CH_U, 1'b0);
            pos = $urandom_range(0, 3);
            for (int i = 0; i < 4; i++) begin
               if (i != pos) c = hex_char(4'($urandom_range(0, 15)));
               else if ($urandom_range(0, 1) == 0) c = 8'($urandom_range(8'h67, 8'hFF));
               else c = 8'($urandom_range(0, 8'h2F));
               send_req(c, 1'b0);
            end
         end
         9: send_req(8'($urandom_range(0, 255)), 1'b0);
         default: begin
            send_req(CH_BSLASH, 1'b0);
            send_req(8'($urandom_range(0, 255)), 1'b0);
         end
      endcase
   endtask

   task automatic send_string();
      int term;
      repeat ($urandom_range(0, 6)) send_fragment();
      term = $urandom_range(0, 9);
      if (term <= 5) begin
         send_req(CH_QUOTE, 1'b0);
      end else if (term == 6) begin
         send_req(8'h00, 1'b1);
      end else if (term == 7) begin
         send_req(8'($urandom_range(0, 8'h1F)), 1'b0);
      end else begin
         // text ends in the middle of an escape or a pair
         case ($urandom_range(0, 4))
            0: send_req(CH_BSLASH, 1'b0);
            1: begin
               send_req(CH_BSLASH, 1'b0);
               send_req(CH_U, 1'b0);
               repeat ($urandom_range(0, 3)) send_req(hex_char(4'($urandom_range(0, 15))), 1'b0);
            end
            2: send_u_escape(high_unit());
            3: begin
               send_u_escape(high_unit());
               send_req(CH_BSLASH, 1'b0);
            end
            default: begin
               send_u_escape(high_unit());
               send_req(CH_BSLASH, 1'b0);
               send_req(CH_U, 1'b0);
               repeat ($urandom_range(0, 3)) send_req(hex_char(4'($urandom_range(0, 15))), 1'b0);
            end
         endcase
         send_req(8'h00, 1'b1);
      end
   endtask

   initial begin : stimulus
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      send_req(8'h00, 1'b0);            // control byte
      send_req(8'hFF, 1'b0);
      send_req(8'h80, 1'b0);
      send_req(8'h7F, 1'b0);
      send_req(8'h20, 1'b0);
      send_req(8'hFF, 1'b1);            // text ends in the body
      send_req(CH_BSLASH, 1'b0);
      send_req(8'h00, 1'b1);            // text ends after a backslash
      send_req(CH_BSLASH, 1'b0);
      send_req(CH_X, 1'b0);             // unknown escape
      send_u_escape(16'hDC00);          // lone low half
      send_u_escape(16'hDBFF);          // high half, then a closing quote
      send_req(CH_QUOTE, 1'b0);
      directed_count = req_count;

      while (req_count < RANDOM_ITEMS / 3) send_string();
      tx_idle_pct = 55;
      rx_idle_pct = 30;
      while (req_count < 2 * RANDOM_ITEMS / 3) send_string();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_wanted <= 1'b1;
      while (req_count < RANDOM_ITEMS) send_string();
      req_tvalid <= 1'b0;

      while (awaited_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests (%0d directed): %0d UTF-8 bytes, %0d closed strings,",
               requests_seen, directed_count, bytes_seen, strings_closed);
      $display("%0d errors; idle mixes 30/55, 55/30 and none, one %0d-cycle output hold-off",
               errors_reported, HOLD_CYCLES);
      if (fail_count == 0) $display("json_string_unescape_to_utf8_core verification clean");
      else $display("json_string_unescape_to_utf8_core verification failed");
      $finish;
   end

endmodule
